FILE: rtl/rcsfd_pkg.sv
// Shared constants, types and helpers for the serial frame channel decoder.
package rcsfd_pkg;

  localparam int unsigned FRAME_BYTES     = 25;
  localparam int unsigned CHANNEL_COUNT   = 16;
  localparam int unsigned CHAN_BITS       = 11;
  localparam int unsigned CHAN_IDX_W      = 4;
  localparam int unsigned COUNT_W         = 5;
  localparam int unsigned FIRST_DATA_BYTE = 1;
  localparam int unsigned LAST_DATA_BYTE  = 22;
  localparam int unsigned DATA_BITS       = (LAST_DATA_BYTE - FIRST_DATA_BYTE + 1) * 8;

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE_0 = 8'h00;
  localparam logic [7:0] END_BYTE_1 = 8'h04;
  localparam logic [7:0] END_BYTE_2 = 8'h14;
  localparam logic [7:0] END_BYTE_3 = 8'h24;
  localparam logic [7:0] END_BYTE_4 = 8'h34;

  localparam logic [COUNT_W-1:0]    CNT_FIRST_DATA = COUNT_W'(FIRST_DATA_BYTE);
  localparam logic [COUNT_W-1:0]    CNT_LAST_DATA  = COUNT_W'(LAST_DATA_BYTE);
  localparam logic [COUNT_W-1:0]    CNT_END_BYTE   = COUNT_W'(FRAME_BYTES - 1);
  localparam logic [CHAN_IDX_W-1:0] CH_LAST        = CHAN_IDX_W'(CHANNEL_COUNT - 1);

  typedef enum logic [2:0] {
    ST_HUNT    = 3'b001,
    ST_COLLECT = 3'b010,
    ST_EMIT    = 3'b100
  } state_e;

  function automatic logic end_byte_ok(input logic [7:0] b);
    return (b == END_BYTE_0) || (b == END_BYTE_1) || (b == END_BYTE_2) ||
           (b == END_BYTE_3) || (b == END_BYTE_4);
  endfunction

endpackage

FILE: rtl/rc_serial_frame_channel_decoder_top.sv
// Serial radio-control frame decoder: syncs on start byte, unpacks 16 channels.
// Bytes are taken one per cycle while hunting or collecting a frame.
// The end byte of a valid frame starts the unpacking through one shift register,
// one channel a cycle while the output does not stall; input stalls while the
// channels are unpacked. The first channel is registered from the emit state.
// Asynchronous active-low reset: hunting, byte count zero, no output beat.
module rc_serial_frame_channel_decoder_top
  import rcsfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAN_IDX_W-1:0] channel_index_o,
  output logic [CHAN_BITS-1:0]  channel_value_o,
  output logic                  last_channel_o
);

  state_e                  state_q, state_d;
  logic [COUNT_W-1:0]      count_q, count_d;
  logic [CHAN_IDX_W-1:0]   ch_q, ch_d;
  logic [DATA_BITS-1:0]    data_q, data_d;
  logic                    out_valid_q, out_valid_d;
  logic [CHAN_IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [CHAN_BITS-1:0]    out_val_q, out_val_d;
  logic                    out_last_q, out_last_d;
  logic                    in_acc, out_free;

  assign in_stall_o = (state_q == ST_EMIT);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ch_d        = ch_q;
    data_d      = data_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_HUNT: begin
        if (in_acc && rx_byte_i == START_BYTE) begin
          count_d = CNT_FIRST_DATA;
          state_d = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (in_acc) begin
          if (count_q >= CNT_FIRST_DATA && count_q <= CNT_LAST_DATA) begin
            data_d = {rx_byte_i, data_q[DATA_BITS-1:8]};
          end
          count_d = count_q + COUNT_W'(1);
          if (count_q == CNT_END_BYTE) begin
            count_d = '0;
            ch_d    = '0;
            state_d = end_byte_ok(rx_byte_i) ? ST_EMIT : ST_HUNT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = ch_q;
          out_val_d   = data_q[CHAN_BITS-1:0];
          out_last_d  = (ch_q == CH_LAST);
          data_d      = {{CHAN_BITS{1'b0}}, data_q[DATA_BITS-1:CHAN_BITS]};
          ch_d        = ch_q + CHAN_IDX_W'(1);
          if (ch_q == CH_LAST) begin
            state_d = ST_HUNT;
          end
        end
      end
      default: begin
        state_d = ST_HUNT;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HUNT;
      count_q     <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = out_idx_q;
  assign channel_value_o = out_val_q;
  assign last_channel_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COLLECT) |-> (count_q >= CNT_FIRST_DATA && count_q <= CNT_END_BYTE))
    else $error("byte count out of frame range");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_channel_o) |-> (channel_index_o == CH_LAST))
    else $error("last flag on wrong channel");

  a_sync_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && state_q == ST_HUNT && rx_byte_i == START_BYTE)
      |=> (state_q == ST_COLLECT && count_q == CNT_FIRST_DATA))
    else $error("start byte did not open a frame");

  a_emit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_EMIT) |-> (ch_q == '0))
    else $error("unpack did not start at channel zero");
`endif

endmodule

FILE: bench/rc_serial_frame_channel_decoder_top_test.sv
// Self-checking bench for the serial frame channel decoder: frame stimulus, byte-level predictor.
module rc_serial_frame_channel_decoder_top_test
  import rcsfd_pkg::*;
();

  localparam int HALF_PERIOD      = 2;
  localparam int RESET_CYCLES     = 8;
  localparam int FRAMES_PER_PHASE = 3;
  localparam int DRAIN_CYCLES     = 40;
  localparam int WATCHDOG_LIMIT   = 2000;

  typedef enum {FILL_ZERO, FILL_ONES, FILL_START, FILL_RAND} fill_e;
  typedef enum {EXP_MODEL, EXP_NONE, EXP_FLAT} check_e;

  typedef struct {
    bit         has_junk;
    logic [7:0] junk;
    fill_e      fill;
    logic [7:0] tail;
    check_e     check;
    logic [CHAN_BITS-1:0] flat;
  } frame_row_t;

  typedef struct {
    logic [CHAN_IDX_W-1:0] idx;
    logic [CHAN_BITS-1:0]  value;
    logic                  last;
  } chan_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            rx_byte_i = 8'h00;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CHAN_IDX_W-1:0] channel_index_o;
  logic [CHAN_BITS-1:0]  channel_value_o;
  logic                  last_channel_o;

  rc_serial_frame_channel_decoder_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_channel_o  (last_channel_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // predictor state
  logic [7:0]         sync_frame [FRAME_BYTES];
  logic [COUNT_W-1:0] sync_count = '0;
  logic               sync_locked = 1'b0;

  chan_beat_t channels_due[$];
  frame_row_t frame_plan [9];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int error_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int beats_checked = 0;
  int quiet_cycles = 0;

  task automatic decode_byte(input logic [7:0] b, input bit emit);
    logic [DATA_BITS-1:0] payload;
    chan_beat_t beat;
    if (!sync_locked) begin
      if (b == START_BYTE) begin
        sync_frame[0] = b;
        sync_count    = COUNT_W'(1);
        sync_locked   = 1'b1;
      end
    end else if (sync_count >= FRAME_BYTES) begin
      sync_count  = '0;
      sync_locked = 1'b0;
    end else begin
      sync_frame[sync_count] = b;
      sync_count = sync_count + COUNT_W'(1);
      if (sync_count == FRAME_BYTES) begin
        if (emit && (sync_frame[FRAME_BYTES-1] inside
            {END_BYTE_0, END_BYTE_1, END_BYTE_2, END_BYTE_3, END_BYTE_4})) begin
          for (int i = 0; i < DATA_BITS / 8; i++)
            payload[8*i +: 8] = sync_frame[FIRST_DATA_BYTE + i];
          for (int k = 0; k < CHANNEL_COUNT; k++) begin
            beat.idx   = CHAN_IDX_W'(k);
            beat.value = payload[CHAN_BITS*k +: CHAN_BITS];
            beat.last  = (k == CHANNEL_COUNT - 1);
            channels_due.push_back(beat);
          end
        end
        sync_count  = '0;
        sync_locked = 1'b0;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit emit);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b, emit);
    bytes_sent++;
  endtask

  task automatic send_frame(input fill_e fill, input logic [7:0] tail, input bit emit);
    logic [7:0] b;
    send_byte(START_BYTE, emit);
    for (int i = 1; i < FRAME_BYTES - 1; i++) begin
      case (fill)
        FILL_ZERO:  b = 8'h00;
        FILL_ONES:  b = 8'hFF;
        FILL_START: b = START_BYTE;
        default:    b = 8'($urandom_range(255));
      endcase
      send_byte(b, emit);
    end
    send_byte(tail, emit);
    frames_sent++;
  endtask

  function automatic logic [7:0] pick_tail();
    case ($urandom_range(9))
      0, 1:    return END_BYTE_0;
      2:       return END_BYTE_1;
      3:       return END_BYTE_2;
      4:       return END_BYTE_3;
      5, 6:    return END_BYTE_4;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic check_beat();
    chan_beat_t want;
    if (channels_due.size() == 0) begin
      $error("unexpected channel beat: index %0d value %0d last %0d",
             channel_index_o, channel_value_o, last_channel_o);
      error_count++;
    end else begin
      want = channels_due.pop_front();
      beats_checked++;
      if (channel_index_o !== want.idx) begin
        $error("channel_index: expected %0d, got %0d", want.idx, channel_index_o);
        error_count++;
      end
      if (channel_value_o !== want.value) begin
        $error("channel_value: expected %0d, got %0d", want.value, channel_value_o);
        error_count++;
      end
      if (last_channel_o !== want.last) begin
        $error("last_channel: expected %0d, got %0d", want.last, last_channel_o);
        error_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      check_beat();
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d channels outstanding",
               WATCHDOG_LIMIT, channels_due.size());
      $display("** rc_serial_frame_channel_decoder_top: FAILED **");
      $finish;
    end
  end

  initial begin
    // flat rows carry a typed expectation, model rows go through the predictor
    frame_plan = '{
      '{1'b1, 8'h00, FILL_ZERO,  END_BYTE_0, EXP_FLAT,  11'h000},
      '{1'b1, 8'hFF, FILL_ONES,  END_BYTE_1, EXP_FLAT,  11'h7FF},
      '{1'b0, 8'h00, FILL_RAND,  END_BYTE_2, EXP_MODEL, 11'h000},
      '{1'b1, 8'hF0, FILL_START, END_BYTE_3, EXP_MODEL, 11'h000},
      '{1'b0, 8'h00, FILL_ONES,  END_BYTE_4, EXP_FLAT,  11'h7FF},
      '{1'b1, 8'h0E, FILL_ONES,  8'hFF,      EXP_NONE,  11'h000},
      '{1'b0, 8'h00, FILL_RAND,  START_BYTE, EXP_NONE,  11'h000},
      '{1'b1, 8'h10, FILL_ZERO,  8'h01,      EXP_NONE,  11'h000},
      '{1'b0, 8'h00, FILL_RAND,  END_BYTE_4, EXP_MODEL, 11'h000}
    };
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 34;
    rx_idle_pct = 62;
    foreach (frame_plan[r]) begin
      if (frame_plan[r].has_junk)
        send_byte(frame_plan[r].junk, frame_plan[r].check == EXP_MODEL);
      send_frame(frame_plan[r].fill, frame_plan[r].tail, frame_plan[r].check == EXP_MODEL);
      if (frame_plan[r].check == EXP_FLAT)
        for (int k = 0; k < CHANNEL_COUNT; k++)
          channels_due.push_back('{CHAN_IDX_W'(k), frame_plan[r].flat,
                                   k == CHANNEL_COUNT - 1});
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 34; rx_idle_pct = 62; end
        1:       begin tx_idle_pct = 62; rx_idle_pct = 34; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      repeat (FRAMES_PER_PHASE) begin
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)), 1'b1);
        send_frame(FILL_RAND, pick_tail(), 1'b1);
      end
    end
    in_valid_i <= 1'b0;

    while (channels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d bytes in %0d frames, checked %0d channel beats",
             bytes_sent, frames_sent, beats_checked);
    $display("frames covered zero, full-scale, start-byte data, all end bytes and bad ends");
    if (error_count == 0)
      $display("** rc_serial_frame_channel_decoder_top: PASSED **");
    else
      $display("** rc_serial_frame_channel_decoder_top: FAILED **");
    $finish;
  end

endmodule
